[rtl/vpft_pkg.sv]
package vpft_pkg;

    typedef enum logic [2:0] {
        OP_WRITE      = 3'd0,
        OP_READ       = 3'd1,
        OP_TICK       = 3'd2,
        OP_DMA        = 3'd3,
        OP_MEM_RETURN = 3'd4,
        OP_SET_NMI    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_SPR_ADDR = 3'd3,
        REG_SPR_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_t;

    localparam int          SPRITE_BYTES = 256;
    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    localparam logic [15:0] VRAM_TOP     = 16'h4000;
    localparam logic [5:0]  ADDR_HI_MASK = 6'h3F;
    localparam logic [8:0]  DOT_LAST     = 9'd340;
    localparam logic [8:0]  LINE_VBLANK  = 9'd241;
    localparam logic [8:0]  LINE_LAST    = 9'd261;
    localparam int          CTRL_INC32   = 2;
    localparam int          CTRL_NMI_EN  = 7;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] addr;
        logic [7:0] wdata;
    } spr_cmd_t;

endpackage

[rtl/vpft_item_if.sv]
interface vpft_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [2:0] reg_index;
    logic [7:0] wdata;
    logic [7:0] mem_data;
    logic       nmi_level;

    modport source (output valid, op, reg_index, wdata, mem_data, nmi_level, input ready);
    modport sink (input valid, op, reg_index, wdata, mem_data, nmi_level, output ready);
endinterface

[rtl/vpft_result_if.sv]
interface vpft_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rdata;
    logic        nmi;
    logic        vblank;
    logic        frame_odd;
    logic [8:0]  line_count;
    logic [8:0]  dot_count;
    logic        mem_req_valid;
    logic        mem_req_write;
    logic [13:0] mem_addr;
    logic [7:0]  mem_wdata;

    modport source (
        output valid, rdata, nmi, vblank, frame_odd, line_count, dot_count,
               mem_req_valid, mem_req_write, mem_addr, mem_wdata,
        input  ready
    );
    modport sink (
        input  valid, rdata, nmi, vblank, frame_odd, line_count, dot_count,
               mem_req_valid, mem_req_write, mem_addr, mem_wdata,
        output ready
    );
endinterface

[rtl/vpft_sprite_ram.sv]
module vpft_sprite_ram
    import vpft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  spr_cmd_t   cmd,
    output logic [7:0] rdata
);

    localparam int AW = $clog2(SPRITE_BYTES);

    logic [7:0]              mem [SPRITE_BYTES];
    logic [SPRITE_BYTES-1:0] valid_reg;
    logic [7:0]              q_reg;
    logic                    q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr[AW-1:0]] <= cmd.wdata;
        end
        if (cmd.rd_en)
        begin
            q_reg <= mem[cmd.addr[AW-1:0]];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[cmd.addr[AW-1:0]] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                q_valid_reg <= valid_reg[cmd.addr[AW-1:0]];
            end
        end
    end

    assign rdata = q_valid_reg ? q_reg : 8'd0;

endmodule

[rtl/vpft_core.sv]
module vpft_core
    import vpft_pkg::*;
#(
    parameter int PALETTE_BYTES = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    vpft_item_if.sink     item,
    vpft_result_if.source result,
    output spr_cmd_t      spr_cmd,
    input  logic [7:0]    spr_rdata
);

    localparam int PW = $clog2(PALETTE_BYTES);

    // Input stage.
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [2:0] idx_reg;
    logic [7:0] wdata_reg;
    logic [7:0] mem_data_reg;
    logic       nmi_level_reg;

    // Architectural state.
    logic [7:0]  ctrl_reg,        ctrl_next;
    logic        vblank_reg,      vblank_next;
    logic [7:0]  spr_addr_reg,    spr_addr_next;
    logic        second_reg,      second_next;
    logic [13:0] temp_addr_reg,   temp_addr_next;
    logic [15:0] video_addr_reg,  video_addr_next;
    logic [7:0]  read_buf_reg,    read_buf_next;
    logic        nmi_reg,         nmi_next;
    logic [8:0]  dot_reg,         dot_next;
    logic [8:0]  line_reg,        line_next;
    logic        frame_reg,       frame_next;
    logic [7:0]  palette_reg [PALETTE_BYTES];

    // Result stage.
    logic        out_valid_reg;
    logic        spr_sel_reg,     spr_sel_next;
    logic [7:0]  rdata_reg,       rdata_next;
    logic        req_valid_reg,   req_valid_next;
    logic        req_write_reg,   req_write_next;
    logic [13:0] req_addr_reg,    req_addr_next;
    logic [7:0]  req_wdata_reg,   req_wdata_next;

    logic        advance;
    logic        process;
    logic        pal_wr;
    logic [PW-1:0] pal_idx;
    logic [8:0]  dot_inc;
    logic [8:0]  line_inc;
    logic [15:0] video_step;
    logic        below_palette;

    assign advance    = !out_valid_reg || result.ready;
    assign process    = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    assign pal_idx       = video_addr_reg[PW-1:0];
    assign dot_inc       = dot_reg + 9'd1;
    assign line_inc      = line_reg + 9'd1;
    assign video_step    = video_addr_reg + (ctrl_reg[CTRL_INC32] ? 16'd32 : 16'd1);
    assign below_palette = video_addr_reg < PALETTE_BASE;

    always_comb
    begin
        ctrl_next       = ctrl_reg;
        vblank_next     = vblank_reg;
        spr_addr_next   = spr_addr_reg;
        second_next     = second_reg;
        temp_addr_next  = temp_addr_reg;
        video_addr_next = video_addr_reg;
        read_buf_next   = read_buf_reg;
        nmi_next        = nmi_reg;
        dot_next        = dot_reg;
        line_next       = line_reg;
        frame_next      = frame_reg;
        pal_wr          = 1'b0;
        spr_sel_next    = 1'b0;
        rdata_next      = 8'd0;
        req_valid_next  = 1'b0;
        req_write_next  = 1'b0;
        req_addr_next   = 14'd0;
        req_wdata_next  = 8'd0;
        spr_cmd.wr_en   = 1'b0;
        spr_cmd.rd_en   = process;
        spr_cmd.addr    = spr_addr_reg;
        spr_cmd.wdata   = wdata_reg;

        unique case (op_t'(op_reg))
            OP_WRITE:
            begin
                unique case (reg_t'(idx_reg))
                    REG_CTRL:
                    begin
                        ctrl_next = wdata_reg;
                    end
                    REG_SPR_ADDR:
                    begin
                        spr_addr_next = wdata_reg;
                    end
                    REG_SPR_DATA:
                    begin
                        spr_cmd.wr_en = process;
                        spr_addr_next = spr_addr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        second_next = !second_reg;
                    end
                    REG_ADDR:
                    begin
                        if (!second_reg)
                        begin
                            temp_addr_next = {wdata_reg[5:0] & ADDR_HI_MASK, temp_addr_reg[7:0]};
                            second_next    = 1'b1;
                        end
                        else
                        begin
                            temp_addr_next  = {temp_addr_reg[13:8], wdata_reg};
                            video_addr_next = {2'b00, temp_addr_reg[13:8], wdata_reg};
                            second_next     = 1'b0;
                        end
                    end
                    REG_DATA:
                    begin
                        if (below_palette)
                        begin
                            req_valid_next = 1'b1;
                            req_write_next = 1'b1;
                            req_addr_next  = video_addr_reg[13:0];
                            req_wdata_next = wdata_reg;
                        end
                        else if (video_addr_reg < VRAM_TOP)
                        begin
                            pal_wr = process;
                        end
                        video_addr_next = video_step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_READ:
            begin
                unique case (reg_t'(idx_reg))
                    REG_STATUS:
                    begin
                        rdata_next  = {vblank_reg, 7'd0};
                        vblank_next = 1'b0;
                        second_next = 1'b0;
                    end
                    REG_SPR_DATA:
                    begin
                        spr_sel_next = 1'b1;
                    end
                    REG_DATA:
                    begin
                        if (below_palette)
                        begin
                            rdata_next     = read_buf_reg;
                            req_valid_next = 1'b1;
                            req_addr_next  = video_addr_reg[13:0];
                        end
                        else
                        begin
                            rdata_next = palette_reg[pal_idx];
                        end
                        video_addr_next = video_step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_TICK:
            begin
                dot_next = dot_inc;
                if (dot_inc > DOT_LAST)
                begin
                    dot_next  = 9'd0;
                    line_next = line_inc;
                    if (line_inc == LINE_VBLANK)
                    begin
                        vblank_next = 1'b1;
                        if (ctrl_reg[CTRL_NMI_EN])
                        begin
                            nmi_next = 1'b1;
                        end
                    end
                    if (line_inc > LINE_LAST)
                    begin
                        line_next   = 9'd0;
                        vblank_next = 1'b0;
                        nmi_next    = 1'b0;
                        frame_next  = !frame_reg;
                    end
                end
            end
            OP_DMA:
            begin
                spr_cmd.wr_en = process;
                spr_addr_next = spr_addr_reg + 8'd1;
            end
            OP_MEM_RETURN:
            begin
                read_buf_next = mem_data_reg;
            end
            OP_SET_NMI:
            begin
                nmi_next = nmi_level_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ctrl_reg       <= 8'd0;
            vblank_reg     <= 1'b0;
            spr_addr_reg   <= 8'd0;
            second_reg     <= 1'b0;
            temp_addr_reg  <= 14'd0;
            video_addr_reg <= 16'd0;
            read_buf_reg   <= 8'd0;
            nmi_reg        <= 1'b0;
            dot_reg        <= 9'd0;
            line_reg       <= 9'd0;
            frame_reg      <= 1'b0;
            for (int i = 0; i < PALETTE_BYTES; i++)
            begin
                palette_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (process)
            begin
                ctrl_reg       <= ctrl_next;
                vblank_reg     <= vblank_next;
                spr_addr_reg   <= spr_addr_next;
                second_reg     <= second_next;
                temp_addr_reg  <= temp_addr_next;
                video_addr_reg <= video_addr_next;
                read_buf_reg   <= read_buf_next;
                nmi_reg        <= nmi_next;
                dot_reg        <= dot_next;
                line_reg       <= line_next;
                frame_reg      <= frame_next;
            end
            if (pal_wr)
            begin
                palette_reg[pal_idx] <= wdata_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            op_reg        <= item.op;
            idx_reg       <= item.reg_index;
            wdata_reg     <= item.wdata;
            mem_data_reg  <= item.mem_data;
            nmi_level_reg <= item.nmi_level;
        end
        if (process)
        begin
            spr_sel_reg   <= spr_sel_next;
            rdata_reg     <= rdata_next;
            req_valid_reg <= req_valid_next;
            req_write_reg <= req_write_next;
            req_addr_reg  <= req_addr_next;
            req_wdata_reg <= req_wdata_next;
        end
    end

    // The state registers always match the most recent result beat.
    assign result.valid         = out_valid_reg;
    assign result.rdata         = spr_sel_reg ? spr_rdata : rdata_reg;
    assign result.nmi           = nmi_reg;
    assign result.vblank        = vblank_reg;
    assign result.frame_odd     = frame_reg;
    assign result.line_count    = line_reg;
    assign result.dot_count     = dot_reg;
    assign result.mem_req_valid = req_valid_reg;
    assign result.mem_req_write = req_write_reg;
    assign result.mem_addr      = req_addr_reg;
    assign result.mem_wdata     = req_wdata_reg;

endmodule

[rtl/video_register_port_and_frame_timing_unit.sv]
// Register port and frame timing of a console picture unit. Each input beat is a bus write,
// bus read, dot tick, sprite DMA byte, memory return or NMI override, and produces exactly
// one result beat, which passes through the input register and then the result register;
// a stalled result side holds it back before the result register. One beat is accepted
// every cycle while the result side keeps up; the rate is set by the single pass through the
// input register, the update logic and the result register, and the sprite memory read lands
// in that same result stage through its registered read port. Sprite entries read as zero
// until written, so the block is ready right after reset with no clearing pass. Data port
// accesses below 0x3F00 leave as a request on the result beat; a read's byte comes back later
// as a memory return.
module video_register_port_and_frame_timing_unit
    import vpft_pkg::*;
#(
    parameter int PALETTE_BYTES = 32
)
(
    input logic           clk,
    input logic           rst_n,
    vpft_item_if.sink     item,
    vpft_result_if.source result
);

    spr_cmd_t   spr_cmd;
    logic [7:0] spr_rdata;

    vpft_core #(
        .PALETTE_BYTES(PALETTE_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .result   (result),
        .spr_cmd  (spr_cmd),
        .spr_rdata(spr_rdata)
    );

    vpft_sprite_ram u_sprite_ram (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (spr_cmd),
        .rdata(spr_rdata)
    );

endmodule

[rtl/vpft_checker.sv]
module vpft_checker
    import vpft_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [7:0]  rdata,
    input logic        vblank,
    input logic [8:0]  line_count,
    input logic [8:0]  dot_count,
    input logic        mem_req_valid,
    input logic        mem_req_write,
    input logic [13:0] mem_addr,
    input logic [7:0]  mem_wdata
);

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (dot_count <= DOT_LAST) && (line_count <= LINE_LAST))
        else $error("dot or line counter out of range");

    a_idle_request_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !mem_req_valid) |-> (!mem_req_write && mem_addr == 14'd0 && mem_wdata == 8'd0))
        else $error("request fields set without a request");

    a_write_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && mem_req_write) |-> (rdata == 8'd0))
        else $error("read data on a write beat");

    a_vblank_outside_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && vblank) |-> (line_count >= LINE_VBLANK))
        else $error("vblank set before its line");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=> (valid && $stable(rdata) && $stable(mem_addr)
                               && $stable(dot_count)))
        else $error("result beat changed while stalled");

endmodule

bind video_register_port_and_frame_timing_unit vpft_checker u_vpft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (result.valid),
    .ready        (result.ready),
    .rdata        (result.rdata),
    .vblank       (result.vblank),
    .line_count   (result.line_count),
    .dot_count    (result.dot_count),
    .mem_req_valid(result.mem_req_valid),
    .mem_req_write(result.mem_req_write),
    .mem_addr     (result.mem_addr),
    .mem_wdata    (result.mem_wdata)
);
